// ===== rtl/sapc_pkg.sv =====
// Shared types, codes and constants of the servo angle to PWM count engine.
package sapc_pkg;

  // Joint table size and PWM frame rate
  localparam int JointCount = 18;
  localparam int PwmRateHz  = 50;

  localparam int JointW    = 6;
  localparam int JointIdxW = $clog2(JointCount);
  localparam int CmdW      = 2;
  localparam int KindW     = 3;
  localparam int UsW       = 15;
  localparam int PwmW      = 12;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int FracBits  = 14;

  // Command codes
  localparam logic [CmdW-1:0] CmdSetAngle = 2'd0;
  localparam logic [CmdW-1:0] CmdSetTrim  = 2'd1;
  localparam logic [CmdW-1:0] CmdSetDir   = 2'd2;
  localparam logic [CmdW-1:0] CmdEnable   = 2'd3;

  // Result kinds
  localparam logic [KindW-1:0] KindAck      = 3'd0;
  localparam logic [KindW-1:0] KindRejected = 3'd1;
  localparam logic [KindW-1:0] KindStored   = 3'd2;
  localparam logic [KindW-1:0] KindWritten  = 3'd3;
  localparam logic [KindW-1:0] KindAllOff   = 3'd4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegCenterCoxa  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCenterFemur = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCenterTibia = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTravelLimit = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPulseMin    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPulseMax    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPulseCenter = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSlope       = 3'd7;

  // 180/(pi*128) in Q16: Q2.13 radians to 1/64 degree
  localparam logic signed [15:0] DegPerRadQ16 = 16'sd29335;

  // counts = floor(us * CountScale / CountDiv)
  localparam longint CountScale = 64'(4096) * 64'(PwmRateHz);
  localparam longint CountDiv   = 64'(1000000);
  localparam longint CountRecip = (CountScale <<< 32) / CountDiv;
  localparam longint UsMaxL     = 64'(32767);

  localparam int CntScaleW = $clog2(CountScale + 1);
  localparam int CntDivW   = $clog2(CountDiv + 1);
  localparam int CntRecipW = $clog2(CountRecip + 1);
  localparam int CntUsKW   = $clog2(UsMaxL * CountScale + 1);
  localparam int CntQW     = $clog2((UsMaxL * CountScale) / CountDiv + 1);
  localparam int CntProdW  = (UsW + CntRecipW > 32 + CntQW) ? UsW + CntRecipW : 32 + CntQW;

  localparam logic [CntScaleW-1:0] CntScale = CntScaleW'(CountScale);
  localparam logic [CntDivW-1:0]   CntDiv   = CntDivW'(CountDiv);
  localparam logic [CntRecipW-1:0] CntRecip = CntRecipW'(CountRecip);

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [JointW-1:0] joint;
    logic signed [15:0] angle;
    logic signed [15:0] trim_value;
    logic signed [7:0]  dir_sign;
    logic               enable_on;
  } sapc_item_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [JointW-1:0] joint_out;
    logic [UsW-1:0]    pulse_us;
    logic [PwmW-1:0]   pwm_counts;
    logic              clamped;
  } sapc_result_t;

  // Controller to datapath step strobes
  typedef struct packed {
    logic load;
    logic deg_mul;
    logic servo_sub;
    logic travel;
    logic slope_mul;
    logic sum;
    logic limit;
    logic cnt_mul;
    logic cnt_fix_mul;
    logic cnt_fix;
    logic finish;
  } sapc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic angle_path;
    logic slot_free;
  } sapc_stat_t;

  // joint mod 3, one bit per step
  function automatic logic [1:0] joint_type(input logic [JointW-1:0] j);
    logic [2:0] r;
    r = '0;
    for (int i = JointW - 1; i >= 0; i--) begin
      r = {r[1:0], j[i]};
      if (r >= 3'd3) begin
        r = r - 3'd3;
      end
    end
    return r[1:0];
  endfunction

endpackage

// ===== rtl/sapc_ifs.sv =====
// Valid/ready channel interfaces for command beats and result beats.
interface sapc_req_if;
  logic                          valid;
  logic                          ready;
  logic [sapc_pkg::CmdW-1:0]     cmd;
  logic [sapc_pkg::JointW-1:0]   joint;
  logic signed [15:0]            angle;
  logic signed [15:0]            trim_value;
  logic signed [7:0]             dir_sign;
  logic                          enable_on;

  modport source (output valid, cmd, joint, angle, trim_value, dir_sign, enable_on,
                  input ready);
  modport sink   (input valid, cmd, joint, angle, trim_value, dir_sign, enable_on,
                  output ready);
endinterface

interface sapc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sapc_pkg::KindW-1:0]    kind;
  logic [sapc_pkg::JointW-1:0]   joint_out;
  logic [sapc_pkg::UsW-1:0]      pulse_us;
  logic [sapc_pkg::PwmW-1:0]     pwm_counts;
  logic                          clamped;

  modport source (output valid, kind, joint_out, pulse_us, pwm_counts, clamped,
                  input ready);
  modport sink   (input valid, kind, joint_out, pulse_us, pwm_counts, clamped,
                  output ready);
endinterface

// ===== rtl/sapc_ctrl.sv =====
// Step sequencer of the servo command engine.
module sapc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sapc_pkg::sapc_stat_t stat,
  output sapc_pkg::sapc_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MULA  = 4'd1;
  localparam logic [3:0] ST_SERVO = 4'd2;
  localparam logic [3:0] ST_TRAV  = 4'd3;
  localparam logic [3:0] ST_SMUL  = 4'd4;
  localparam logic [3:0] ST_SUM   = 4'd5;
  localparam logic [3:0] ST_LIM   = 4'd6;
  localparam logic [3:0] ST_CNTA  = 4'd7;
  localparam logic [3:0] ST_CNTB  = 4'd8;
  localparam logic [3:0] ST_CNTC  = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load = accept;
        if (accept) state_next = ST_MULA;
      end
      ST_MULA: begin
        cmd.deg_mul = 1'b1;
        state_next  = stat.angle_path ? ST_SERVO : ST_DONE;
      end
      ST_SERVO: begin
        cmd.servo_sub = 1'b1;
        state_next    = ST_TRAV;
      end
      ST_TRAV: begin
        cmd.travel = 1'b1;
        state_next = ST_SMUL;
      end
      ST_SMUL: begin
        cmd.slope_mul = 1'b1;
        state_next    = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_LIM;
      end
      ST_LIM: begin
        cmd.limit  = 1'b1;
        state_next = ST_CNTA;
      end
      ST_CNTA: begin
        cmd.cnt_mul = 1'b1;
        state_next  = ST_CNTB;
      end
      ST_CNTB: begin
        cmd.cnt_fix_mul = 1'b1;
        state_next      = ST_CNTC;
      end
      ST_CNTC: begin
        cmd.cnt_fix = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register can take the beat
        cmd.finish = stat.slot_free;
        if (stat.slot_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_MULA) && !in_ready)
    else $error("accepted beat did not start a command");

  a_short_path: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULA) && !stat.angle_path |=> (state == ST_DONE))
    else $error("non-angle command entered the angle pipeline");

  a_count_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CNTC) |=> (state == ST_DONE) && !in_ready)
    else $error("count correction not followed by result step");

endmodule

// ===== rtl/sapc_dp.sv =====
// Datapath: registers, joint tables, angle to pulse arithmetic and result register.
module sapc_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sapc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [sapc_pkg::CfgDataW-1:0]    cfg_data,
  input  sapc_pkg::sapc_item_t             item,
  input  sapc_pkg::sapc_cmd_t              cmd,
  output sapc_pkg::sapc_stat_t             stat,
  output logic                             res_valid,
  input  logic                             res_ready,
  output sapc_pkg::sapc_result_t           res
);

  // Configuration registers
  logic signed [14:0] center_coxa;
  logic signed [14:0] center_femur;
  logic signed [14:0] center_tibia;
  logic [13:0]        travel_limit;
  logic [14:0]        pulse_min;
  logic [14:0]        pulse_max;
  logic [14:0]        pulse_center;
  logic [15:0]        slope;

  // Joint state
  logic signed [15:0] trim_table [sapc_pkg::JointCount];
  logic               dir_table  [sapc_pkg::JointCount];
  logic               enabled;

  // Captured command beat
  sapc_pkg::sapc_item_t          cur;
  logic                          joint_ok;
  logic [sapc_pkg::JointIdxW-1:0] jidx;

  // Arithmetic stages
  logic signed [31:0] deg_prod;
  logic signed [31:0] deg_round;
  logic signed [15:0] deg;
  logic signed [14:0] center_sel;
  logic signed [16:0] servo;
  logic signed [16:0] trav_pos;
  logic signed [16:0] trav_neg;
  logic               over_hi;
  logic               over_lo;
  logic signed [14:0] servo_lim;
  logic signed [14:0] servo_adj;
  logic               clamp;
  logic signed [31:0] slope_prod;
  logic signed [17:0] base;
  logic signed [31:0] base_q;
  logic signed [32:0] psum;
  logic signed [32:0] lo;
  logic signed [32:0] hi;
  logic signed [32:0] p_lo;
  logic signed [32:0] p_lim;
  logic [sapc_pkg::UsW-1:0]      us;
  logic [sapc_pkg::CntProdW-1:0] recip_prod;
  logic [sapc_pkg::CntUsKW-1:0]  us_k;
  logic [sapc_pkg::CntQW-1:0]    q_est;
  logic [sapc_pkg::CntUsKW-1:0]  qd;
  logic [sapc_pkg::CntUsKW-1:0]  rem;
  logic [sapc_pkg::CntQW-1:0]    q_fix;
  logic [sapc_pkg::PwmW-1:0]     pwm;
  sapc_pkg::sapc_result_t        res_next;

  assign joint_ok = (cur.joint < sapc_pkg::JointW'(sapc_pkg::JointCount));
  assign jidx     = cur.joint[sapc_pkg::JointIdxW-1:0];

  assign stat.angle_path = (cur.cmd == sapc_pkg::CmdSetAngle) && joint_ok;
  assign stat.slot_free  = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_coxa  <= '0;
      center_femur <= '0;
      center_tibia <= '0;
      travel_limit <= 14'd5760;
      pulse_min    <= 15'd500;
      pulse_max    <= 15'd2500;
      pulse_center <= 15'd1500;
      slope        <= 16'd2844;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sapc_pkg::RegCenterCoxa:  center_coxa  <= $signed(cfg_data[14:0]);
        sapc_pkg::RegCenterFemur: center_femur <= $signed(cfg_data[14:0]);
        sapc_pkg::RegCenterTibia: center_tibia <= $signed(cfg_data[14:0]);
        sapc_pkg::RegTravelLimit: travel_limit <= cfg_data[13:0];
        sapc_pkg::RegPulseMin:    pulse_min    <= cfg_data[14:0];
        sapc_pkg::RegPulseMax:    pulse_max    <= cfg_data[14:0];
        sapc_pkg::RegPulseCenter: pulse_center <= cfg_data[14:0];
        sapc_pkg::RegSlope:       slope        <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) cur <= item;
  end

  // Degrees: round Q16 product to 1/64 degree, then take off the joint type center
  always_comb begin
    deg_round = deg_prod + 32'sd32768;
    deg       = deg_round[31:16];
    unique case (sapc_pkg::joint_type(cur.joint))
      2'd0:    center_sel = center_coxa;
      2'd1:    center_sel = center_femur;
      default: center_sel = center_tibia;
    endcase
  end

  always_comb begin
    trav_pos  = $signed({3'b000, travel_limit});
    trav_neg  = -trav_pos;
    over_hi   = servo > trav_pos;
    over_lo   = servo < trav_neg;
    servo_lim = over_hi ? trav_pos[14:0] : (over_lo ? trav_neg[14:0] : servo[14:0]);
  end

  // Base pulse from the stored trim of the joint
  always_comb begin
    base   = $signed({3'b000, pulse_center}) + $signed({{2{trim_table[jidx][15]}},
             trim_table[jidx]});
    base_q = {base, 14'b0};
    lo     = $signed({4'b0000, pulse_min, 14'b0});
    hi     = $signed({4'b0000, pulse_max, 14'b0});
    p_lo   = (psum < lo) ? lo : psum;
    p_lim  = (p_lo > hi) ? hi : p_lo;
  end

  always_comb begin
    recip_prod = sapc_pkg::CntProdW'(us) * sapc_pkg::CntProdW'(sapc_pkg::CntRecip);
    rem        = us_k - qd;
    q_fix      = q_est + sapc_pkg::CntQW'(rem >= sapc_pkg::CntUsKW'(sapc_pkg::CntDiv));
  end

  always_ff @(posedge clk) begin
    if (cmd.deg_mul) deg_prod <= cur.angle * sapc_pkg::DegPerRadQ16;
    if (cmd.servo_sub) begin
      servo <= $signed({deg[15], deg}) - $signed({{2{center_sel[14]}}, center_sel});
    end
    if (cmd.travel) begin
      clamp     <= over_hi || over_lo;
      servo_adj <= dir_table[jidx] ? -servo_lim : servo_lim;
    end
    if (cmd.slope_mul) slope_prod <= servo_adj * $signed({1'b0, slope});
    if (cmd.sum)       psum <= $signed({base_q[31], base_q}) +
                               $signed({slope_prod[31], slope_prod});
    if (cmd.limit)     us <= p_lim[sapc_pkg::FracBits +: sapc_pkg::UsW];
    if (cmd.cnt_mul) begin
      us_k  <= sapc_pkg::CntUsKW'(us) * sapc_pkg::CntUsKW'(sapc_pkg::CntScale);
      q_est <= recip_prod[32 +: sapc_pkg::CntQW];
    end
    if (cmd.cnt_fix_mul) begin
      qd <= sapc_pkg::CntUsKW'(q_est) * sapc_pkg::CntUsKW'(sapc_pkg::CntDiv);
    end
    if (cmd.cnt_fix) pwm <= q_fix[sapc_pkg::PwmW-1:0];
  end

  always_comb begin
    res_next           = '0;
    res_next.joint_out = cur.joint;
    if (cur.cmd == sapc_pkg::CmdEnable) begin
      res_next.joint_out = '0;
      res_next.kind      = cur.enable_on ? sapc_pkg::KindAck : sapc_pkg::KindAllOff;
    end else if (!joint_ok) begin
      res_next.kind = sapc_pkg::KindRejected;
    end else if (cur.cmd == sapc_pkg::CmdSetAngle) begin
      res_next.kind       = enabled ? sapc_pkg::KindWritten : sapc_pkg::KindStored;
      res_next.pulse_us   = us;
      res_next.pwm_counts = pwm;
      res_next.clamped    = clamp;
    end else begin
      res_next.kind = sapc_pkg::KindAck;
    end
  end

  // Apply table and enable side effects when the result is committed
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      for (int i = 0; i < sapc_pkg::JointCount; i++) begin
        trim_table[i] <= '0;
        dir_table[i]  <= 1'b0;
      end
    end else if (cmd.finish) begin
      if (cur.cmd == sapc_pkg::CmdEnable) begin
        enabled <= cur.enable_on;
      end else if (joint_ok && (cur.cmd == sapc_pkg::CmdSetTrim)) begin
        trim_table[jidx] <= cur.trim_value;
      end else if (joint_ok && (cur.cmd == sapc_pkg::CmdSetDir)) begin
        dir_table[jidx] <= cur.dir_sign[7];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) res <= res_next;
  end

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> res_valid)
    else $error("committed result beat not presented");

  a_travel_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.travel |=> (servo_adj <= $signed({1'b0, travel_limit})) &&
                   (servo_adj >= -$signed({1'b0, travel_limit})))
    else $error("servo offset outside travel limit");

  a_pulse_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.limit |=> (us <= pulse_max) && ((us >= pulse_min) || (pulse_min > pulse_max)))
    else $error("pulse outside configured limits");

endmodule

// ===== rtl/servo_angle_to_pwm_counts.sv =====
// Servo command engine top level: sequencer, datapath and channel hookup.
// Takes one command beat at a time. Set angle runs through a chain of registered
// steps (angle multiply, center subtract, travel clamp, slope multiply, pulse sum,
// pulse limit, then three steps that turn the pulse into PWM counts by reciprocal
// multiply and one correction) before the result beat; set trim, set direction,
// enable control and rejected joints pass from the angle multiply step straight
// to the result step. The result sits in an output register, so the next command
// is taken while a result waits; the engine stalls only if a second result is
// ready before the first has been taken.
// Configuration writes are taken on any cycle and must come while idle.
module servo_angle_to_pwm_counts (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sapc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [sapc_pkg::CfgDataW-1:0] cfg_data,
  sapc_req_if.sink                      req,
  sapc_rsp_if.source                    rsp
);

  sapc_pkg::sapc_cmd_t    cmd;
  sapc_pkg::sapc_stat_t   stat;
  sapc_pkg::sapc_item_t   item;
  sapc_pkg::sapc_result_t res;
  logic                   res_valid;

  assign item.cmd        = req.cmd;
  assign item.joint      = req.joint;
  assign item.angle      = req.angle;
  assign item.trim_value = req.trim_value;
  assign item.dir_sign   = req.dir_sign;
  assign item.enable_on  = req.enable_on;

  sapc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sapc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res_ready (rsp.ready),
    .res       (res)
  );

  assign rsp.valid      = res_valid;
  assign rsp.kind       = res.kind;
  assign rsp.joint_out  = res.joint_out;
  assign rsp.pulse_us   = res.pulse_us;
  assign rsp.pwm_counts = res.pwm_counts;
  assign rsp.clamped    = res.clamped;

endmodule
